// ----- design/tlbpt_pkg.sv -----
// ----------------------------------------------------------------------------
// TLB and page-table translator package
// Shared sizes, derived widths and the sequencer state type.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

	localparam int TLB_ENTRIES  = 16;
	localparam int PAGE_COUNT   = 1024;
	localparam int FRAME_COUNT  = 256;
	localparam int OFFSET_WIDTH = 10;

	localparam int VA_W    = 20;
	localparam int PA_W    = 18;
	localparam int PAGE_W  = $clog2(PAGE_COUNT);
	localparam int FRAME_W = $clog2(FRAME_COUNT);
	localparam int FC_W    = $clog2(FRAME_COUNT + 2);
	localparam int TIME_W  = 32;

	typedef enum logic [8:0] {
		S_CLEAR = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_LOOK  = 9'b000000100,
		S_SCAN  = 9'b000001000,
		S_EV1   = 9'b000010000,
		S_EV2   = 9'b000100000,
		S_EV3   = 9'b001000000,
		S_EV4   = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

endpackage

// ----- design/tlbpt_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tlbpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- design/tlb_page_table_translator_core.sv -----
// ----------------------------------------------------------------------------
// TLB and page-table address translator
// Translates one virtual address per transfer with a TLB, a page table and
// FIFO or least-recently-used frame replacement on page faults.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_stall, virtual_address) takes one address
// per transfer. The output channel (out_valid, out_stall) returns one result:
// phys_addr, tlb_hit and page_fault. The replacement policy is set by
// cfg_write_en and cfg_write_data; the user must write it only while the
// block is idle; the block itself does not enforce this.
// An LRU eviction scans every frame through the owner, page-table and
// use-time memories, one frame per cycle.
// One address is in work at a time; in_stall is high until the next one can
// be taken. A finished result waits in the output register while the
// receiver stalls, and the next address is accepted meanwhile.
// After reset the page table is cleared one entry per cycle, and no address
// is accepted until that pass completes.
// ----------------------------------------------------------------------------
module tlb_page_table_translator_core #(
	parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write_en,
	input  logic                       cfg_write_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [tlbpt_pkg::VA_W-1:0] virtual_address,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [tlbpt_pkg::PA_W-1:0] phys_addr,
	output logic                       tlb_hit,
	output logic                       page_fault
);

	localparam int PAGE_W  = tlbpt_pkg::PAGE_W;
	localparam int FRAME_W = tlbpt_pkg::FRAME_W;
	localparam int FC_W    = tlbpt_pkg::FC_W;
	localparam int TIME_W  = tlbpt_pkg::TIME_W;
	localparam int OFF_W   = tlbpt_pkg::OFFSET_WIDTH;
	localparam int TI_W    = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

	tlbpt_pkg::state_t state_q;

	logic                mode_q;
	logic [TIME_W-1:0]   access_q;
	logic [FC_W-1:0]     fault_cnt_q;
	logic [FRAME_W-1:0]  fifo_ptr_q;
	logic [PAGE_W-1:0]   clr_q;
	logic [PAGE_W-1:0]   page_q;
	logic [OFF_W-1:0]    offset_q;
	logic [FRAME_W-1:0]  frame_q;
	logic [PAGE_W-1:0]   owner_q;
	logic                hit_q;
	logic                fault_q;

	logic [PAGE_W-1:0]   tag_q   [TLB_ENTRIES];
	logic [FRAME_W-1:0]  tframe_q[TLB_ENTRIES];
	logic [TLB_ENTRIES-1:0] tvalid_q;
	logic [TI_W-1:0]     ins_ptr_q;

	logic [FRAME_W:0]    scan_cnt_q;
	logic                v_s1, v_s2;
	logic [FRAME_W-1:0]  f_s1, f_s2;
	logic                best_found_q;
	logic [FRAME_W-1:0]  best_q;
	logic [TIME_W-1:0]   best_time_q;

	logic                out_valid_q;
	logic [tlbpt_pkg::PA_W-1:0] pa_q;
	logic                out_hit_q, out_fault_q;

	logic                in_xfer;
	logic [PAGE_W-1:0]   in_page;
	logic                scan_issue;

	logic                pt_we;
	logic [PAGE_W-1:0]   pt_waddr, pt_raddr;
	logic [FRAME_W:0]    pt_wdata, pt_rdata;
	logic                own_we;
	logic [FRAME_W-1:0]  own_raddr;
	logic [PAGE_W-1:0]   own_rdata;
	logic [TIME_W-1:0]   lut_rdata;

	logic                tlb_match;
	logic [FRAME_W-1:0]  tlb_match_frame;
	logic [FC_W-1:0]     fc_next;
	logic                resident;
	logic                load_out;

	assign in_stall = (state_q != tlbpt_pkg::S_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign in_page  = virtual_address[OFF_W +: PAGE_W];
	assign scan_issue = (state_q == tlbpt_pkg::S_SCAN) &&
		(scan_cnt_q < (FRAME_W+1)'(tlbpt_pkg::FRAME_COUNT));
	assign fc_next = (fault_cnt_q <= FC_W'(tlbpt_pkg::FRAME_COUNT)) ?
		fault_cnt_q + 1'b1 : fault_cnt_q;
	assign resident = pt_rdata[FRAME_W] && (pt_rdata[FRAME_W-1:0] == frame_q);
	assign load_out = (state_q == tlbpt_pkg::S_DONE) && (!out_valid_q || !out_stall);

	always_comb begin
		tlb_match       = 1'b0;
		tlb_match_frame = '0;
		for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
			if (tvalid_q[i] && tag_q[i] == page_q) begin
				tlb_match       = 1'b1;
				tlb_match_frame = tframe_q[i];
			end
		end
	end

	always_comb begin
		pt_we    = 1'b0;
		pt_waddr = page_q;
		pt_wdata = {1'b1, frame_q};
		case (state_q)
			tlbpt_pkg::S_CLEAR: begin
				pt_we    = 1'b1;
				pt_waddr = clr_q;
				pt_wdata = '0;
			end
			tlbpt_pkg::S_EV3: begin
				pt_we    = resident;
				pt_waddr = owner_q;
				pt_wdata = '0;
			end
			tlbpt_pkg::S_EV4: begin
				pt_we = 1'b1;
			end
			default: begin
				pt_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		case (state_q)
			tlbpt_pkg::S_IDLE:                    pt_raddr = in_page;
			tlbpt_pkg::S_SCAN, tlbpt_pkg::S_EV2:  pt_raddr = own_rdata;
			default:                              pt_raddr = page_q;
		endcase
	end

	assign own_we    = (state_q == tlbpt_pkg::S_EV4);
	assign own_raddr = (state_q == tlbpt_pkg::S_SCAN) ? scan_cnt_q[FRAME_W-1:0] : frame_q;

	tlbpt_ram #(.WIDTH(FRAME_W + 1), .DEPTH(tlbpt_pkg::PAGE_COUNT)) u_page_table (
		.clk   (clk),
		.we    (pt_we),
		.waddr (pt_waddr),
		.wdata (pt_wdata),
		.raddr (pt_raddr),
		.rdata (pt_rdata)
	);

	tlbpt_ram #(.WIDTH(PAGE_W), .DEPTH(tlbpt_pkg::FRAME_COUNT)) u_frame_owner (
		.clk   (clk),
		.we    (own_we),
		.waddr (frame_q),
		.wdata (page_q),
		.raddr (own_raddr),
		.rdata (own_rdata)
	);

	tlbpt_ram #(.WIDTH(TIME_W), .DEPTH(tlbpt_pkg::PAGE_COUNT)) u_last_use (
		.clk   (clk),
		.we    (in_xfer),
		.waddr (in_page),
		.wdata (access_q + 1'b1),
		.raddr (own_rdata),
		.rdata (lut_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_write_en) begin
			mode_q <= cfg_write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= tlbpt_pkg::S_CLEAR;
			clr_q        <= '0;
			access_q     <= '0;
			fault_cnt_q  <= '0;
			fifo_ptr_q   <= '0;
			tvalid_q     <= '0;
			ins_ptr_q    <= '0;
			scan_cnt_q   <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			best_found_q <= 1'b0;
		end else begin
			v_s1 <= scan_issue;
			v_s2 <= v_s1 && (state_q == tlbpt_pkg::S_SCAN);
			case (state_q)
				tlbpt_pkg::S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == PAGE_W'(tlbpt_pkg::PAGE_COUNT - 1)) begin
						state_q <= tlbpt_pkg::S_IDLE;
					end
				end
				tlbpt_pkg::S_IDLE: begin
					if (in_xfer) begin
						access_q <= access_q + 1'b1;
						state_q  <= tlbpt_pkg::S_LOOK;
					end
				end
				tlbpt_pkg::S_LOOK: begin
					if (tlb_match) begin
						state_q <= tlbpt_pkg::S_DONE;
					end else if (pt_rdata[FRAME_W]) begin
						tag_q[ins_ptr_q]    <= page_q;
						tframe_q[ins_ptr_q] <= pt_rdata[FRAME_W-1:0];
						tvalid_q[ins_ptr_q] <= 1'b1;
						ins_ptr_q <= (ins_ptr_q == TI_W'(TLB_ENTRIES - 1)) ?
							'0 : ins_ptr_q + 1'b1;
						state_q <= tlbpt_pkg::S_DONE;
					end else begin
						fault_cnt_q <= fc_next;
						if (!mode_q) begin
							fifo_ptr_q <= (fifo_ptr_q ==
								FRAME_W'(tlbpt_pkg::FRAME_COUNT - 1)) ?
								'0 : fifo_ptr_q + 1'b1;
							state_q <= tlbpt_pkg::S_EV1;
						end else if (fc_next <= FC_W'(tlbpt_pkg::FRAME_COUNT)) begin
							state_q <= tlbpt_pkg::S_EV1;
						end else begin
							scan_cnt_q   <= '0;
							best_found_q <= 1'b0;
							state_q      <= tlbpt_pkg::S_SCAN;
						end
					end
				end
				tlbpt_pkg::S_SCAN: begin
					if (scan_issue) begin
						scan_cnt_q <= scan_cnt_q + 1'b1;
					end
					if (v_s2 && pt_rdata[FRAME_W] && pt_rdata[FRAME_W-1:0] == f_s2 &&
						(!best_found_q || lut_rdata < best_time_q)) begin
						best_found_q <= 1'b1;
					end
					if (!scan_issue && !v_s1 && !v_s2) begin
						state_q <= tlbpt_pkg::S_EV1;
					end
				end
				tlbpt_pkg::S_EV1: state_q <= tlbpt_pkg::S_EV2;
				tlbpt_pkg::S_EV2: state_q <= tlbpt_pkg::S_EV3;
				tlbpt_pkg::S_EV3: begin
					if (resident) begin
						for (int i = 0; i < TLB_ENTRIES; i++) begin
							if (tframe_q[i] == frame_q) begin
								tvalid_q[i] <= 1'b0;
							end
						end
					end
					state_q <= tlbpt_pkg::S_EV4;
				end
				tlbpt_pkg::S_EV4: begin
					tag_q[ins_ptr_q]    <= page_q;
					tframe_q[ins_ptr_q] <= frame_q;
					tvalid_q[ins_ptr_q] <= 1'b1;
					ins_ptr_q <= (ins_ptr_q == TI_W'(TLB_ENTRIES - 1)) ?
						'0 : ins_ptr_q + 1'b1;
					state_q <= tlbpt_pkg::S_DONE;
				end
				tlbpt_pkg::S_DONE: begin
					if (load_out) begin
						state_q <= tlbpt_pkg::S_IDLE;
					end
				end
				default: state_q <= tlbpt_pkg::S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		f_s1 <= scan_cnt_q[FRAME_W-1:0];
		f_s2 <= f_s1;
		if (in_xfer) begin
			page_q   <= in_page;
			offset_q <= virtual_address[OFF_W-1:0];
		end
		if (state_q == tlbpt_pkg::S_EV2) begin
			owner_q <= own_rdata;
		end
		case (state_q)
			tlbpt_pkg::S_LOOK: begin
				hit_q   <= tlb_match;
				fault_q <= !tlb_match && !pt_rdata[FRAME_W];
				best_q  <= '0;
				if (tlb_match) begin
					frame_q <= tlb_match_frame;
				end else if (pt_rdata[FRAME_W]) begin
					frame_q <= pt_rdata[FRAME_W-1:0];
				end else if (!mode_q) begin
					frame_q <= fifo_ptr_q;
				end else begin
					frame_q <= FRAME_W'(fc_next - 1'b1);
				end
			end
			tlbpt_pkg::S_SCAN: begin
				if (v_s2 && pt_rdata[FRAME_W] && pt_rdata[FRAME_W-1:0] == f_s2 &&
					(!best_found_q || lut_rdata < best_time_q)) begin
					best_q      <= f_s2;
					best_time_q <= lut_rdata;
				end
				if (!scan_issue && !v_s1 && !v_s2) begin
					frame_q <= best_q;
				end
			end
			default: begin
				frame_q <= frame_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			pa_q        <= {frame_q, offset_q};
			out_hit_q   <= hit_q;
			out_fault_q <= fault_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign phys_addr  = pa_q;
	assign tlb_hit    = out_hit_q;
	assign page_fault = out_fault_q;

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state is not one-hot");

	a_hit_no_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(tlb_hit && page_fault))
		else $error("result flags both a TLB hit and a page fault");

	a_scan_only_lru: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tlbpt_pkg::S_SCAN) |-> mode_q)
		else $error("frame scan running outside LRU mode");

	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (state_q == tlbpt_pkg::S_IDLE) && out_valid)
		else $error("result transfer did not return the sequencer to idle");

endmodule

// ----- test/tb_tlb_page_table_translator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the TLB and page-table address translator
// Drives virtual addresses with random gaps and output stalls, predicts each
// translation with a local model of the TLB, page table and both replacement
// policies, and compares every result field by field.
// ----------------------------------------------------------------------------
module tb_tlb_page_table_translator_core;

	localparam int TLB_ENTRIES  = tlbpt_pkg::TLB_ENTRIES;
	localparam int PAGE_COUNT   = tlbpt_pkg::PAGE_COUNT;
	localparam int FRAME_COUNT  = tlbpt_pkg::FRAME_COUNT;
	localparam int OFFSET_WIDTH = tlbpt_pkg::OFFSET_WIDTH;
	localparam int VA_W         = tlbpt_pkg::VA_W;
	localparam int PA_W         = tlbpt_pkg::PA_W;
	localparam int PAGE_W       = tlbpt_pkg::PAGE_W;
	localparam int FRAME_W      = tlbpt_pkg::FRAME_W;

	localparam int IDLE_WAIT = FRAME_COUNT + 40;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic [PA_W-1:0] pa;
		logic            hit;
		logic            fault;
	} xlate_t;

	logic clk;
	logic arst_n;
	logic cfg_write_en;
	logic cfg_write_data;
	logic in_valid;
	logic in_stall;
	logic [VA_W-1:0] virtual_address;
	logic out_valid;
	logic out_stall;
	logic [PA_W-1:0] phys_addr;
	logic tlb_hit;
	logic page_fault;

	tlb_page_table_translator_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
		.in_valid(in_valid), .in_stall(in_stall), .virtual_address(virtual_address),
		.out_valid(out_valid), .out_stall(out_stall),
		.phys_addr(phys_addr), .tlb_hit(tlb_hit), .page_fault(page_fault)
	);

	// Predictor state.
	logic                 lru_mode;
	logic [PAGE_W-1:0]    tag_q [TLB_ENTRIES];
	logic [FRAME_W-1:0]   tframe_q [TLB_ENTRIES];
	logic                 tvalid_q [TLB_ENTRIES];
	int unsigned          ins_ptr;
	logic                 pvalid_q [PAGE_COUNT];
	logic [FRAME_W-1:0]   pframe_q [PAGE_COUNT];
	logic [PAGE_W-1:0]    owner_q [FRAME_COUNT];
	logic [31:0]          used_at [PAGE_COUNT];
	logic [31:0]          accesses;
	int unsigned          faults;
	logic [FRAME_W-1:0]   fifo_ptr;

	xlate_t expected_xlates[$];
	int errors = 0;
	int quiet_cycles = 0;
	bit hold_receiver = 0;
	int max_gap = 3;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic xlate_t translate(logic [VA_W-1:0] va);
		xlate_t r;
		logic [PAGE_W-1:0] pg;
		logic [FRAME_W-1:0] fr;
		logic [FRAME_W-1:0] best;
		logic [31:0] best_t;
		logic found;
		logic [PAGE_W-1:0] op;
		pg = va[OFFSET_WIDTH +: PAGE_W];
		fr = 0;
		r.hit = 0;
		r.fault = 0;
		accesses = accesses + 1;
		used_at[pg] = accesses;
		for (int i = 0; i < TLB_ENTRIES; i++) begin
			if (!r.hit && tvalid_q[i] && tag_q[i] == pg) begin
				fr = tframe_q[i];
				r.hit = 1;
			end
		end
		if (!r.hit) begin
			if (pvalid_q[pg]) begin
				fr = pframe_q[pg];
			end else begin
				r.fault = 1;
				if (faults <= FRAME_COUNT) faults++;
				if (!lru_mode) begin
					fr = fifo_ptr;
					fifo_ptr = fifo_ptr + 1;
				end else if (faults <= FRAME_COUNT) begin
					fr = FRAME_W'(faults - 1);
				end else begin
					best = 0;
					best_t = 0;
					found = 0;
					for (int f = 0; f < FRAME_COUNT; f++) begin
						op = owner_q[f];
						if (pvalid_q[op] && pframe_q[op] == f) begin
							if (!found || used_at[op] < best_t) begin
								best = FRAME_W'(f);
								best_t = used_at[op];
								found = 1;
							end
						end
					end
					fr = best;
				end
				op = owner_q[fr];
				if (pvalid_q[op] && pframe_q[op] == fr) begin
					pvalid_q[op] = 0;
					for (int i = 0; i < TLB_ENTRIES; i++)
						if (tvalid_q[i] && tframe_q[i] == fr) tvalid_q[i] = 0;
				end
				pvalid_q[pg] = 1;
				pframe_q[pg] = fr;
				owner_q[fr] = pg;
			end
			tag_q[ins_ptr] = pg;
			tframe_q[ins_ptr] = fr;
			tvalid_q[ins_ptr] = 1;
			ins_ptr = (ins_ptr + 1) % TLB_ENTRIES;
		end
		r.pa = PA_W'({fr, va[OFFSET_WIDTH-1:0]});
		return r;
	endfunction

	function automatic int pick_gap();
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		return $urandom_range(0, max_gap);
	endfunction

	task automatic send_address(logic [VA_W-1:0] va);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		virtual_address <= va;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_xlates.push_back(translate(va));
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		while (expected_xlates.size() != 0) @(posedge clk);
		repeat (IDLE_WAIT) @(posedge clk);
	endtask

	task automatic set_mode(logic m);
		wait_drained();
		cfg_write_en <= 1;
		cfg_write_data <= m;
		@(posedge clk);
		cfg_write_en <= 0;
		lru_mode = m;
	endtask

	function automatic logic [VA_W-1:0] make_va(int unsigned pg_hi);
		return {PAGE_W'($urandom_range(0, pg_hi)), OFFSET_WIDTH'($urandom)};
	endfunction

	task automatic test_directed();
		send_address('0);
		send_address('1);
		send_address('0);
		send_address({10'd1023, 10'd0});
		send_address({10'd1, 10'h3ff});
		send_address({10'd1, 10'h155});
		for (int i = 0; i < 18; i++) send_address({PAGE_W'(i + 2), OFFSET_WIDTH'(i * 37)});
	endtask

	task automatic test_fifo_random(int n, int unsigned pg_hi);
		for (int i = 0; i < n; i++) send_address(make_va(pg_hi));
	endtask

	task automatic test_lru_fill_and_evict();
		set_mode(1);
		for (int i = 0; i < 300; i++) send_address(make_va(1023));
		for (int i = 0; i < 200; i++) send_address(make_va(300));
	endtask

	task automatic test_backpressure();
		max_gap = 0;
		hold_receiver = 1;
		for (int i = 0; i < 6; i++) send_address(make_va(40));
		max_gap = 3;
		wait_drained();
	endtask

	task automatic test_mode_switches();
		set_mode(0);
		test_fifo_random(150, 1023);
		set_mode(1);
		test_fifo_random(200, 1023);
		set_mode(0);
		test_fifo_random(150, 60);
		set_mode(1);
		test_fifo_random(150, 1023);
	endtask

	// Receiver stalls; one long hold-off is counted in this process.
	initial begin
		out_stall = 0;
		forever begin
			@(posedge clk);
			if (hold_receiver) begin
				out_stall <= 1;
				repeat (300) @(posedge clk);
				out_stall <= 0;
				hold_receiver = 0;
			end else if ($urandom_range(0, 3) == 0) begin
				out_stall <= 1;
				repeat (pick_gap() + 1) @(posedge clk);
				out_stall <= 0;
			end
		end
	end

	// Result checker and watchdog.
	always @(posedge clk) begin
		xlate_t e;
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_xlates.size() == 0) begin
				$display("%t unexpected transfer pa=%h hit=%b fault=%b", $time,
					phys_addr, tlb_hit, page_fault);
				errors++;
			end else begin
				e = expected_xlates.pop_front();
				if (phys_addr !== e.pa) begin
					$display("%t pa expected %h actual %h", $time, e.pa, phys_addr);
					errors++;
				end
				if (tlb_hit !== e.hit) begin
					$display("%t hit expected %b actual %b", $time, e.hit, tlb_hit);
					errors++;
				end
				if (page_fault !== e.fault) begin
					$display("%t fault expected %b actual %b", $time, e.fault, page_fault);
					errors++;
				end
			end
		end
	end

	initial begin
		arst_n = 0;
		cfg_write_en = 0;
		cfg_write_data = 0;
		in_valid = 0;
		virtual_address = '0;
		lru_mode = 0;
		ins_ptr = 0;
		accesses = 0;
		faults = 0;
		fifo_ptr = 0;
		for (int i = 0; i < TLB_ENTRIES; i++) begin
			tvalid_q[i] = 0; tag_q[i] = 0; tframe_q[i] = 0;
		end
		for (int i = 0; i < PAGE_COUNT; i++) begin
			pvalid_q[i] = 0; pframe_q[i] = 0; used_at[i] = 0;
		end
		for (int i = 0; i < FRAME_COUNT; i++) owner_q[i] = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		test_directed();
		test_fifo_random(170, 1023);
		test_backpressure();
		test_lru_fill_and_evict();
		test_mode_switches();
		wait_drained();
		if (errors == 0 && expected_xlates.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
